[design/assert_macros.svh]
// assertion macros shared by the tracker rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[design/spdt_pkg.sv]
// shared types and constants of the sound peak direction tracker
// no dependencies; imported by every module of the block
package spdt_pkg;

    // history row size
    localparam int HISTORY_DEPTH = 10;
    localparam int IDX_W         = $clog2(HISTORY_DEPTH);
    localparam int HLEN_W        = 4;
    localparam int CMP_W         = (HLEN_W > IDX_W + 1) ? HLEN_W + 1 : IDX_W + 2;

    // field widths
    localparam int DIR_W   = 4;
    localparam int LEVEL_W = 23;
    localparam int POS_W   = 16;
    localparam int COLOR_W = 2;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_SILENT    = 4'd13;
    localparam logic [DIR_W-1:0] DIR_LIMIT     = 4'd12;
    localparam logic [DIR_W-1:0] DIR_WRAP      = 4'd11;
    localparam logic [DIR_W-1:0] DIR_MAX_SECT  = 4'd10;
    localparam logic [DIR_W-1:0] DIR_GROUP_0   = 4'd0;
    localparam logic [DIR_W-1:0] DIR_GROUP_1   = 4'd4;
    localparam logic [DIR_W-1:0] DIR_GROUP_2   = 4'd8;
    localparam logic [DIR_W-1:0] DIR_ODD_ADD   = 4'd2;
    localparam logic [DIR_W-1:0] DIST_ADJ      = 4'd2;
    localparam logic [DIR_W-1:0] DIST_WRAP     = 4'd10;

    // lit colors
    localparam logic [COLOR_W-1:0] COLOR_OFF  = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_BLUE = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_RED  = 2'd2;

    // register map
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_LEN   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HISTORY_LEN = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SILENCE_THR = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LEVEL_EN    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LOUD_LEVEL  = 3'd4;

    // register reset values
    localparam logic [POS_W-1:0]   FRAME_LEN_RST   = 16'd1500;
    localparam logic [HLEN_W-1:0]  HISTORY_LEN_RST = 4'd2;
    localparam logic [LEVEL_W-1:0] SILENCE_THR_RST = 23'd30000;
    localparam logic [LEVEL_W-1:0] LOUD_LEVEL_RST  = 23'd200000;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIR,
        S_SCAN,
        S_EMIT
    } state_t;

    // running summary of distinct history values, passed cell to cell
    typedef struct packed {
        logic             started;
        logic             many;
        logic             kinds2;
        logic [DIR_W-1:0] seen0;
        logic [DIR_W-1:0] seen1;
    } hist_sum_t;

endpackage

[design/spdt_cell.sv]
// one history cell: holds one direction entry and folds it into the summary
// depends on spdt_pkg
module spdt_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     shift,
    input  logic                     take_new,
    input  logic                     take_next,
    input  logic [spdt_pkg::DIR_W-1:0] new_dir,
    input  logic [spdt_pkg::DIR_W-1:0] next_dir,
    input  spdt_pkg::hist_sum_t      sum_in,
    output logic [spdt_pkg::DIR_W-1:0] value,
    output spdt_pkg::hist_sum_t      sum_out
);
    import spdt_pkg::*;

    logic [DIR_W-1:0] value_reg, value_next;
    hist_sum_t        sum_reg, sum_next;

    // entry update on a history shift
    always_comb begin
        value_next = value_reg;
        if (shift) begin
            if (take_new) begin
                value_next = new_dir;
            end else if (take_next) begin
                value_next = next_dir;
            end
        end
    end

    // fold own entry into the incoming summary
    always_comb begin
        sum_next = sum_in;
        if (!sum_in.started) begin
            sum_next.started = 1'b1;
            sum_next.many    = 1'b0;
            sum_next.kinds2  = 1'b0;
            sum_next.seen0   = value_reg;
            sum_next.seen1   = '0;
        end else if (sum_in.many) begin
            sum_next = sum_in;
        end else if (value_reg == sum_in.seen0
                     || (sum_in.kinds2 && value_reg == sum_in.seen1)) begin
            sum_next = sum_in;
        end else if (sum_in.kinds2) begin
            sum_next.many = 1'b1;
        end else begin
            sum_next.kinds2 = 1'b1;
            sum_next.seen1  = value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= DIR_SILENT;
            sum_reg   <= '0;
        end else begin
            value_reg <= value_next;
            sum_reg   <= sum_next;
        end
    end

    assign value   = value_reg;
    assign sum_out = sum_reg;

endmodule

[design/spdt_chain.sv]
// row of history cells and the stable direction pick at the active end
// depends on spdt_pkg, spdt_cell and assert_macros.svh
`include "assert_macros.svh"

module spdt_chain (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       shift,
    input  logic [spdt_pkg::IDX_W-1:0] last_idx,
    input  logic [spdt_pkg::DIR_W-1:0] new_dir,
    input  logic [spdt_pkg::DIR_W-1:0] last_stable,
    output logic [spdt_pkg::DIR_W-1:0] stable_dir
);
    import spdt_pkg::*;

    logic [DIR_W-1:0] value_w [HISTORY_DEPTH];
    hist_sum_t        sum_w   [HISTORY_DEPTH];
    hist_sum_t        sum_sel;
    logic [DIR_W-1:0] diff;
    logic [DIR_W-1:0] low_val;

    // cells: entry i takes entry i+1 below the active end, the new direction at it
    for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
        logic [DIR_W-1:0] nxt;
        hist_sum_t        sin;
        logic             take_new_c;
        logic             take_next_c;

        if (i == HISTORY_DEPTH - 1) begin : g_end
            assign nxt = new_dir;
        end else begin : g_mid
            assign nxt = value_w[i+1];
        end

        if (i == 0) begin : g_first
            assign sin = '0;
        end else begin : g_rest
            assign sin = sum_w[i-1];
        end

        assign take_new_c  = ({1'b0, last_idx} == (IDX_W+1)'(i));
        assign take_next_c = ({1'b0, last_idx} > (IDX_W+1)'(i));

        spdt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift     (shift),
            .take_new  (take_new_c),
            .take_next (take_next_c),
            .new_dir   (new_dir),
            .next_dir  (nxt),
            .sum_in    (sin),
            .value     (value_w[i]),
            .sum_out   (sum_w[i])
        );
    end

    // summary settled at the active end of the row
    assign sum_sel = sum_w[last_idx];
    assign diff    = (sum_sel.seen0 > sum_sel.seen1) ? sum_sel.seen0 - sum_sel.seen1
                                                     : sum_sel.seen1 - sum_sel.seen0;
    assign low_val = (sum_sel.seen0 < sum_sel.seen1) ? sum_sel.seen0 : sum_sel.seen1;

    // distinct-value rules
    always_comb begin
        stable_dir = last_stable;
        if (!sum_sel.many) begin
            if (!sum_sel.kinds2) begin
                stable_dir = sum_sel.seen0;
            end else if (diff == DIST_ADJ) begin
                stable_dir = low_val + 4'd1;
            end else if (diff == DIST_WRAP) begin
                stable_dir = DIR_WRAP;
            end
        end
    end

    `ASSERT_NEVER(a_many_needs_two, aclk, aresetn,
                  sum_sel.many && !sum_sel.kinds2)
    `ASSERT_NEVER(a_started_at_end, aclk, aresetn,
                  $past(shift, HISTORY_DEPTH + 1) && !sum_sel.started)
    `ASSERT_CLK(a_silent_reset_entry, aclk, aresetn,
                $rose(aresetn) |-> value_w[0] == DIR_SILENT)

endmodule

[design/sound_peak_direction_tracker_top.sv]
// Sound peak direction tracker. Each request carries one 24-bit sample (signed
// upper word plus top byte of the lower word); samples are only accepted while
// the sequencer is idle. The sample that closes a frame is followed by a
// direction state, a scan with the stability summary rippling one history cell
// per clock through the row of cells, and an output state. One result
// comes out per frame. Configuration is an APB-style port, one 32-bit register
// per word address: frame_len, history_len, silence_threshold, color_enable,
// loud_level. Results may wait in the output register while new samples flow.
// depends on spdt_pkg, spdt_chain and assert_macros.svh
`include "assert_macros.svh"

module sound_peak_direction_tracker_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    // sample channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [15:0]           s_sample_high,
    input  logic [15:0]                  s_sample_low,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [spdt_pkg::DIR_W-1:0]   m_stable_dir,
    output logic [spdt_pkg::DIR_W-1:0]   m_coarse_dir,
    output logic [spdt_pkg::LEVEL_W-1:0] m_peak_level,
    output logic [spdt_pkg::POS_W-1:0]   m_peak_position,
    output logic [spdt_pkg::COLOR_W-1:0] m_lit_color,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [spdt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import spdt_pkg::*;

    localparam int SCAN_W = $clog2(HISTORY_DEPTH);

    // configuration registers
    logic [POS_W-1:0]   frame_len_reg;
    logic [HLEN_W-1:0]  history_len_reg;
    logic [LEVEL_W-1:0] silence_thr_reg;
    logic               level_en_reg;
    logic [LEVEL_W-1:0] loud_level_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic               cfg_wr;

    // frame state
    state_t             state_reg, state_next;
    logic [SCAN_W-1:0]  cnt_reg, cnt_next;
    logic [POS_W-1:0]   word_pos_reg, word_pos_next;
    logic [LEVEL_W-1:0] peak_reg, peak_next;
    logic [POS_W-1:0]   offset_reg, offset_next;
    logic [DIR_W-1:0]   dir_reg, dir_next;
    logic [DIR_W-1:0]   last_stable_reg, last_stable_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [DIR_W-1:0]   m_stable_reg, m_stable_next;
    logic [DIR_W-1:0]   m_coarse_reg, m_coarse_next;
    logic [LEVEL_W-1:0] m_level_reg, m_level_next;
    logic [POS_W-1:0]   m_pos_reg, m_pos_next;
    logic [COLOR_W-1:0] m_color_reg, m_color_next;

    logic [23:0]        sample;
    logic               accept;
    logic               frame_end;
    logic               shift;
    logic [17:0]        off3;
    logic [DIR_W-1:0]   dir_calc;
    logic [IDX_W-1:0]   last_idx;
    logic [DIR_W-1:0]   stable_dir;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_len_reg   <= FRAME_LEN_RST;
            history_len_reg <= HISTORY_LEN_RST;
            silence_thr_reg <= SILENCE_THR_RST;
            level_en_reg    <= 1'b0;
            loud_level_reg  <= LOUD_LEVEL_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_FRAME_LEN:   frame_len_reg   <= pwdata[POS_W-1:0];
                REG_HISTORY_LEN: history_len_reg <= pwdata[HLEN_W-1:0];
                REG_SILENCE_THR: silence_thr_reg <= pwdata[LEVEL_W-1:0];
                REG_LEVEL_EN:    level_en_reg    <= pwdata[0];
                REG_LOUD_LEVEL:  loud_level_reg  <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_FRAME_LEN:   prdata = {16'd0, frame_len_reg};
            REG_HISTORY_LEN: prdata = {28'd0, history_len_reg};
            REG_SILENCE_THR: prdata = {9'd0, silence_thr_reg};
            REG_LEVEL_EN:    prdata = {31'd0, level_en_reg};
            REG_LOUD_LEVEL:  prdata = {9'd0, loud_level_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // sample assembly and frame end test
    assign sample    = {s_sample_high, s_sample_low[15:8]};
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign frame_end = ({1'b0, word_pos_reg} + 17'd2) >= {1'b0, frame_len_reg};

    // coarse direction: offset < len/3 iff 3*offset+3 <= len, same for 2*len/3
    assign off3 = ({2'b0, offset_reg} << 1) + {2'b0, offset_reg} + 18'd3;

    always_comb begin
        if (peak_reg < silence_thr_reg) begin
            dir_calc = DIR_SILENT;
        end else begin
            if (off3 <= {2'b0, frame_len_reg}) begin
                dir_calc = DIR_GROUP_0;
            end else if (off3 <= {1'b0, frame_len_reg, 1'b0}) begin
                dir_calc = DIR_GROUP_1;
            end else begin
                dir_calc = DIR_GROUP_2;
            end
            if (offset_reg[1:0] != 2'd0) begin
                dir_calc = dir_calc + DIR_ODD_ADD;
            end
        end
    end

    // active end of the history row
    always_comb begin
        if (history_len_reg == '0) begin
            last_idx = '0;
        end else if (CMP_W'(history_len_reg) > CMP_W'(HISTORY_DEPTH)) begin
            last_idx = IDX_W'(HISTORY_DEPTH - 1);
        end else begin
            last_idx = IDX_W'(history_len_reg - 4'd1);
        end
    end

    spdt_chain u_chain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .shift       (shift),
        .last_idx    (last_idx),
        .new_dir     (dir_calc),
        .last_stable (last_stable_reg),
        .stable_dir  (stable_dir)
    );

    // sequencer and frame tracking
    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        word_pos_next    = word_pos_reg;
        peak_next        = peak_reg;
        offset_next      = offset_reg;
        dir_next         = dir_reg;
        last_stable_next = last_stable_reg;
        shift            = 1'b0;
        m_valid_next     = m_valid_reg && !m_ready;
        m_stable_next    = m_stable_reg;
        m_coarse_next    = m_coarse_reg;
        m_level_next     = m_level_reg;
        m_pos_next       = m_pos_reg;
        m_color_next     = m_color_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (!sample[23] && sample[LEVEL_W-1:0] > peak_reg) begin
                        peak_next   = sample[LEVEL_W-1:0];
                        offset_next = word_pos_reg;
                    end
                    if (frame_end) begin
                        state_next = S_DIR;
                    end else begin
                        word_pos_next = word_pos_reg + 16'd2;
                    end
                end
            end
            S_DIR: begin
                dir_next   = dir_calc;
                shift      = 1'b1;
                cnt_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SCAN_W'(HISTORY_DEPTH - 1)) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_stable_next = stable_dir;
                    m_coarse_next = dir_reg;
                    m_level_next  = peak_reg;
                    m_pos_next    = offset_reg;
                    if (stable_dir < DIR_LIMIT) begin
                        m_color_next = (level_en_reg && peak_reg >= loud_level_reg)
                                       ? COLOR_RED : COLOR_BLUE;
                    end else begin
                        m_color_next = COLOR_OFF;
                    end
                    last_stable_next = stable_dir;
                    peak_next        = '0;
                    word_pos_next    = '0;
                    state_next       = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            word_pos_reg    <= '0;
            peak_reg        <= '0;
            offset_reg      <= '0;
            dir_reg         <= '0;
            last_stable_reg <= DIR_SILENT;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            word_pos_reg    <= word_pos_next;
            peak_reg        <= peak_next;
            offset_reg      <= offset_next;
            dir_reg         <= dir_next;
            last_stable_reg <= last_stable_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_stable_reg <= m_stable_next;
        m_coarse_reg <= m_coarse_next;
        m_level_reg  <= m_level_next;
        m_pos_reg    <= m_pos_next;
        m_color_reg  <= m_color_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_stable_dir    = m_stable_reg;
    assign m_coarse_dir    = m_coarse_reg;
    assign m_peak_level    = m_level_reg;
    assign m_peak_position = m_pos_reg;
    assign m_lit_color     = m_color_reg;

    `ASSERT_CLK(a_color_matches_dir, aclk, aresetn,
                m_valid |-> ((m_lit_color == COLOR_OFF) == (m_stable_dir >= DIR_LIMIT)))
    `ASSERT_CLK(a_coarse_legal, aclk, aresetn,
                m_valid |-> (m_coarse_dir == DIR_SILENT
                             || (!m_coarse_dir[0] && m_coarse_dir <= DIR_MAX_SECT)))
    `ASSERT_NEVER(a_word_pos_even, aclk, aresetn, word_pos_reg[0])
    `ASSERT_CLK(a_emit_frees_frame, aclk, aresetn,
                (state_reg == S_EMIT && state_next == S_IDLE) |=> m_valid && peak_reg == '0)

endmodule
